// File: src/fts_pkg.sv
// Shared widths, codes and control types for the Fenwick tree sum and kth block.
package fts_pkg;

  // Default sizing of the tree.
  localparam int FTS_SIZE      = 1024;
  localparam int FTS_SUM_WIDTH = 64;

  // Transaction field widths.
  localparam int KIND_W  = 3;
  localparam int IDXA_W  = 11;
  localparam int IDXB_W  = 10;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 64;
  localparam int POS_W   = 11;
  localparam int CFG_W   = 11;

  // Query index width: one more bit than index_a so that index_a - 1 fits.
  localparam int QIDX_W = IDXA_W + 1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_POINT_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREFIX    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE_SUM = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE_ADD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_KTH       = 3'd4;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] fts_op_t;

  localparam fts_op_t OP_NONE       = 4'd0;
  localparam fts_op_t OP_CAPTURE    = 4'd1;
  localparam fts_op_t OP_CLEAR      = 4'd2;
  localparam fts_op_t OP_LD_ADD_A   = 4'd3;
  localparam fts_op_t OP_LD_ADD_B   = 4'd4;
  localparam fts_op_t OP_LD_PFX_A   = 4'd5;
  localparam fts_op_t OP_LD_PFX_B   = 4'd6;
  localparam fts_op_t OP_LD_PFX_AM1 = 4'd7;
  localparam fts_op_t OP_LD_KTH     = 4'd8;
  localparam fts_op_t OP_WALK_ADD   = 4'd9;
  localparam fts_op_t OP_WALK_PFX   = 4'd10;
  localparam fts_op_t OP_KTH_RD     = 4'd11;
  localparam fts_op_t OP_OUT        = 4'd12;

  // Command from the controller to the datapath.
  typedef struct packed {
    fts_op_t op;
  } fts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              clr_last;
    logic              add_run;
    logic              pfx_run;
    logic              step_zero;
    logic              kth_hit;
    logic              out_free;
  } fts_sts_t;

endpackage

// File: src/fts_if.sv
// Valid/ready channel interfaces for requests and results.
interface fts_req_if;
  import fts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [IDXA_W-1:0]  index_a;
  logic [IDXB_W-1:0]         index_b;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, index_a, index_b, value, input ready);
  modport sink (input valid, kind, index_a, index_b, value, output ready);
endinterface

interface fts_rsp_if;
  import fts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total;
  logic [POS_W-1:0]          position;

  modport source (output valid, total, position, input ready);
  modport sink (input valid, total, position, output ready);
endinterface

// File: src/fts_datapath.sv
// Datapath: node memory, tree walk registers, accumulators and result register.
module fts_datapath #(
  parameter int SIZE      = fts_pkg::FTS_SIZE,
  parameter int SUM_WIDTH = fts_pkg::FTS_SUM_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fts_pkg::CFG_W-1:0]          cfg_data,
  input  fts_pkg::fts_cmd_t                  cmd,
  output fts_pkg::fts_sts_t                  sts,
  input  logic [fts_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [fts_pkg::IDXA_W-1:0]  in_index_a,
  input  logic [fts_pkg::IDXB_W-1:0]         in_index_b,
  input  logic signed [fts_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fts_pkg::TOTAL_W-1:0] out_total,
  output logic [fts_pkg::POS_W-1:0]          out_position
);
  import fts_pkg::*;

  localparam int AW = $clog2(SIZE);
  localparam int IW = $clog2(SIZE + 1);
  localparam int JW = IW + 1;
  localparam int QW = QIDX_W;
  localparam int XW = ((JW > QW) ? JW : QW) + 1;
  localparam int SW = SUM_WIDTH;

  // Kind of the read that is in flight.
  localparam logic [1:0] PEND_ADD = 2'd0;
  localparam logic [1:0] PEND_PFX = 2'd1;
  localparam logic [1:0] PEND_KTH = 2'd2;

  // Captured transaction.
  logic [KIND_W-1:0]         kind_r;
  logic signed [IDXA_W-1:0]  a_r;
  logic [IDXB_W-1:0]         b_r;
  logic signed [VALUE_W-1:0] v_r;

  // Tree size and walk state.
  logic [IW-1:0] n_r, n_nxt;
  logic [IW-1:0] top_r, top_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] step_r, step_nxt;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [SW-1:0] save_r, save_nxt;
  logic [SW-1:0] delta_r, delta_nxt;

  // Read in flight.
  logic          pend_r, pend_nxt;
  logic [1:0]    pend_op_r, pend_op_nxt;
  logic [AW-1:0] wa_r, wa_nxt;

  // Node memory.
  logic [SW-1:0] mem [SIZE];
  logic [SW-1:0] rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  // Result register.
  logic                      out_valid_r, out_valid_nxt;
  logic signed [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;

  // Helper values.
  logic [JW-1:0]             lowbit;
  logic [JW-1:0]             probe;
  logic                      probe_ok;
  logic [SW-1:0]             val_sw;
  logic [SW-1:0]             acc_upd;
  logic [SW-1:0]             trial;
  logic signed [63:0]        trial64;
  logic signed [63:0]        k64;
  logic signed [QW-1:0]      a_q;
  logic signed [QW-1:0]      add_idx;
  logic                      add_ok;
  logic signed [QW-1:0]      pfx_idx;
  logic [XW-1:0]             pfx_u;
  logic [XW-1:0]             add_u;
  logic [XW-1:0]             n_x;
  logic [JW-1:0]             pfx_j;
  logic [IW-1:0]             cfg_n;
  logic [SW-1:0]             range_sw;

  // Common arithmetic terms.
  assign lowbit   = j_r & (~j_r + JW'(1));
  assign probe    = JW'(pos_r) + JW'(step_r);
  assign probe_ok = (step_r != '0) && (probe <= JW'(n_r));
  assign val_sw   = SW'(v_r);
  assign acc_upd  = (pend_r && pend_op_r == PEND_PFX) ? acc_r + rdata_r : acc_r;
  assign trial    = acc_r + rdata_r;
  assign trial64  = 64'(signed'(trial));
  assign k64      = 64'(v_r);
  assign a_q      = QW'(a_r);
  assign n_x      = XW'(n_r);
  assign range_sw = save_r - acc_r;

  // Effective size from a configuration write: zero acts as one, clamp to SIZE.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = IW'(1);
    end else if (32'(cfg_data) > 32'(SIZE)) begin
      cfg_n = IW'(SIZE);
    end else begin
      cfg_n = IW'(cfg_data);
    end
  end

  // Largest power of two not above the active size.
  always_comb begin
    top_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (n_r[i]) begin
        top_nxt = IW'(1) << i;
      end
    end
  end

  // Point add start index: index_a, or index_b + 1 for the second half of a range add.
  always_comb begin
    if (cmd.op == OP_LD_ADD_B) begin
      add_idx = QW'(b_r) + QW'(1);
    end else begin
      add_idx = a_q;
    end
    add_u  = XW'(add_idx[QW-2:0]);
    add_ok = !add_idx[QW-1] && (add_u < n_x);
  end

  // Prefix start node, with negative indices giving an empty walk and saturation at n-1.
  always_comb begin
    case (cmd.op)
      OP_LD_PFX_B:   pfx_idx = QW'(b_r);
      OP_LD_PFX_AM1: pfx_idx = a_q - QW'(1);
      default:       pfx_idx = a_q;
    endcase
    pfx_u = XW'(pfx_idx[QW-2:0]);
    if (pfx_idx[QW-1]) begin
      pfx_j = '0;
    end else if (pfx_u >= n_x) begin
      pfx_j = JW'(n_r);
    end else begin
      pfx_j = JW'(pfx_u + XW'(1));
    end
  end

  // Next-state logic of the walk registers and memory controls.
  always_comb begin
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    save_nxt      = save_r;
    delta_nxt     = delta_r;
    pend_nxt      = 1'b0;
    pend_op_nxt   = pend_op_r;
    wa_nxt        = wa_r;
    rd_en         = 1'b0;
    rd_addr       = AW'(j_r - JW'(1));
    wr_en         = 1'b0;
    wr_addr       = clr_r;
    wr_data       = '0;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_pos_nxt   = out_pos_r;

    // Resolve the read issued in the previous cycle.
    if (pend_r) begin
      case (pend_op_r)
        PEND_ADD: begin
          wr_en   = 1'b1;
          wr_addr = wa_r;
          wr_data = rdata_r + delta_r;
        end
        PEND_PFX: begin
          acc_nxt = acc_upd;
        end
        PEND_KTH: begin
          if (trial64 < k64) begin
            acc_nxt = trial;
            pos_nxt = pos_r + step_r;
          end
          step_nxt = step_r >> 1;
        end
        default: begin
        end
      endcase
    end

    // Operation requested by the controller.
    case (cmd.op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
      end
      OP_LD_ADD_A: begin
        j_nxt     = add_ok ? JW'(add_u) + JW'(1) : '1;
        delta_nxt = val_sw;
      end
      OP_LD_ADD_B: begin
        j_nxt     = add_ok ? JW'(add_u) + JW'(1) : '1;
        delta_nxt = SW'(0) - val_sw;
      end
      OP_LD_PFX_A, OP_LD_PFX_B: begin
        j_nxt   = pfx_j;
        acc_nxt = '0;
      end
      OP_LD_PFX_AM1: begin
        save_nxt = acc_upd;
        j_nxt    = pfx_j;
        acc_nxt  = '0;
      end
      OP_LD_KTH: begin
        pos_nxt  = '0;
        step_nxt = top_r;
        acc_nxt  = '0;
      end
      OP_WALK_ADD: begin
        rd_en       = 1'b1;
        rd_addr     = AW'(j_r - JW'(1));
        pend_nxt    = 1'b1;
        pend_op_nxt = PEND_ADD;
        wa_nxt      = rd_addr;
        j_nxt       = j_r + lowbit;
      end
      OP_WALK_PFX: begin
        rd_en       = 1'b1;
        rd_addr     = AW'(j_r - JW'(1));
        pend_nxt    = 1'b1;
        pend_op_nxt = PEND_PFX;
        j_nxt       = j_r - lowbit;
      end
      OP_KTH_RD: begin
        if (probe_ok) begin
          rd_en       = 1'b1;
          rd_addr     = AW'(probe - JW'(1));
          pend_nxt    = 1'b1;
          pend_op_nxt = PEND_KTH;
        end else begin
          step_nxt = step_r >> 1;
        end
      end
      default: begin
      end
    endcase

    // Result register: load on request, drain when the sink takes it.
    if (cmd.op == OP_OUT) begin
      out_valid_nxt = 1'b1;
      out_total_nxt = '0;
      out_pos_nxt   = '0;
      case (kind_r)
        KIND_PREFIX:    out_total_nxt = 64'(signed'(acc_r));
        KIND_RANGE_SUM: out_total_nxt = 64'(signed'(range_sw));
        KIND_KTH:       out_pos_nxt   = POS_W'(pos_r + IW'(1));
        default: begin
        end
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // A configuration write sets the size and restarts the clearing pass.
    if (cfg_we) begin
      n_nxt   = cfg_n;
      clr_nxt = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= IW'(SIZE);
      top_r       <= '0;
      clr_r       <= '0;
      j_r         <= '0;
      pos_r       <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      pend_op_r   <= PEND_ADD;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      top_r       <= top_nxt;
      clr_r       <= clr_nxt;
      j_r         <= j_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      pend_op_r   <= pend_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      kind_r <= in_kind;
      a_r    <= in_index_a;
      b_r    <= in_index_b;
      v_r    <= in_value;
    end
    acc_r       <= acc_nxt;
    save_r      <= save_nxt;
    delta_r     <= delta_nxt;
    wa_r        <= wa_nxt;
    out_total_r <= out_total_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // Node memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Status to the controller.
  always_comb begin
    sts.kind      = kind_r;
    sts.clr_last  = (clr_r == AW'(SIZE - 1));
    sts.add_run   = (j_r <= JW'(n_r));
    sts.pfx_run   = (j_r != '0);
    sts.step_zero = (step_r == '0);
    sts.kth_hit   = probe_ok;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_total    = out_total_r;
  assign out_position = out_pos_r;

`ifndef ASSERT_OFF
  // A read never targets the node whose updated value is being written back.
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && pend_r && pend_op_r == PEND_ADD) |-> (rd_addr != wr_addr))
    else $error("read and write-back address collide");

  // A waiting result is never overwritten.
  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  // The kth step is a single power of two or zero.
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(step_r))
    else $error("kth step is not a power of two");
`endif

endmodule

// File: src/fts_ctrl.sv
// Controller: sequences the clearing pass, tree walks and result hand-off.
module fts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_ready,
  input  fts_pkg::fts_sts_t sts,
  output fts_pkg::fts_cmd_t cmd
);
  import fts_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_PFX   = 4'd4;
  localparam logic [3:0] S_KTH   = 4'd5;
  localparam logic [3:0] S_KWAIT = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       second_r, second_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command.
  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd.op     = OP_NONE;

    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_START;
        end
      end
      S_START: begin
        second_nxt = 1'b0;
        case (sts.kind)
          KIND_POINT_ADD: begin
            cmd.op    = OP_LD_ADD_A;
            state_nxt = S_ADD;
          end
          KIND_RANGE_ADD: begin
            cmd.op     = OP_LD_ADD_A;
            second_nxt = 1'b1;
            state_nxt  = S_ADD;
          end
          KIND_PREFIX: begin
            cmd.op    = OP_LD_PFX_A;
            state_nxt = S_PFX;
          end
          KIND_RANGE_SUM: begin
            cmd.op     = OP_LD_PFX_B;
            second_nxt = 1'b1;
            state_nxt  = S_PFX;
          end
          KIND_KTH: begin
            cmd.op    = OP_LD_KTH;
            state_nxt = S_KTH;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ADD: begin
        if (sts.add_run) begin
          cmd.op = OP_WALK_ADD;
        end else if (second_r) begin
          cmd.op     = OP_LD_ADD_B;
          second_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PFX: begin
        if (sts.pfx_run) begin
          cmd.op = OP_WALK_PFX;
        end else if (second_r) begin
          cmd.op     = OP_LD_PFX_AM1;
          second_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_KTH: begin
        if (sts.step_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_KTH_RD;
          if (sts.kth_hit) begin
            state_nxt = S_KWAIT;
          end
        end
      end
      S_KWAIT: begin
        state_nxt = S_KTH;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Any configuration write restarts the clearing pass.
    if (cfg_we) begin
      state_nxt = S_CLEAR;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A configuration write always leads into the clearing pass.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_CLEAR))
    else $error("configuration write did not start clearing");

  // An accepted transaction is dispatched in the next cycle.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_we) |=> (state_r == S_START))
    else $error("accepted transaction not dispatched");
`endif

endmodule

// File: src/fenwick_tree_sum_and_kth.sv
// Fenwick tree sum and kth search: top level joining controller and datapath.
// Point add and prefix sum walk the tree once and range requests walk it twice; kth search
// waits on read data at each lifting step whose probe lies within the active size.
// Transactions are handled one at a time: in_ready is high only while the controller is idle.
// Reset and every active_size write run a clearing pass over all SIZE nodes with in_ready low.
// Reset is synchronous and active low; active_size returns to SIZE.
module fenwick_tree_sum_and_kth #(
  parameter int SIZE      = fts_pkg::FTS_SIZE,
  parameter int SUM_WIDTH = fts_pkg::FTS_SUM_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [fts_pkg::CFG_W-1:0] cfg_data,
  fts_req_if.sink                   in_req,
  fts_rsp_if.source                 out_rsp
);
  import fts_pkg::*;

  fts_cmd_t cmd;
  fts_sts_t sts;
  logic     in_ready;

  assign in_req.ready = in_ready;

  // Sequencer.
  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Node memory and arithmetic.
  fts_datapath #(
    .SIZE      (SIZE),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_req.kind),
    .in_index_a   (in_req.index_a),
    .in_index_b   (in_req.index_b),
    .in_value     (in_req.value),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .out_total    (out_rsp.total),
    .out_position (out_rsp.position)
  );

endmodule
